### design/assert_macros.svh
// Assertion macros for the point store block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### design/pps_pkg.sv
// ----------------------------------------------------------------------------
// Point store package
// Shared constants, codes and types of the polyline point store.
// ----------------------------------------------------------------------------
package pps_pkg;
  localparam int MaxPointsDef = 1024;
  localparam int MaxLinesDef  = 256;
  localparam int CoordBitsDef = 16;
  localparam int DistW = 34;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0, MODE_START = 3'd1, MODE_UPDATE = 3'd2,
    MODE_DELETE = 3'd3, MODE_SEARCH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LWRITE, S_LREAD, S_LINC, S_SHREAD, S_SHWRITE,
    S_FINDREAD, S_FINDCHK, S_LSHREAD, S_LSHWRITE, S_SREAD, S_SDIFF, S_SCALC, S_DONE
  } state_t;
endpackage

### design/polyline_point_store_unit.sv
// ----------------------------------------------------------------------------
// Polyline point store
// Packed point store with polylines and nearest point search.
// ----------------------------------------------------------------------------
// Points sit in two RAMs (x and y) and polyline lengths in a third, all
// driven by one sequencer. Update, the empty, full and range cases and the
// unused modes finish directly; start writes the point and a new length,
// and an append to an existing polyline reads the last length and writes
// it back plus one. Delete shifts each later point down, walks the lengths
// up to and including the owner, and shifts later lengths down if the
// owner empties. Search reads each stored point, registers its differences
// and compares the squared distance. One transaction is in flight at a
// time; the result sits in an output register, and the input opens again
// on the cycle after that result has been taken.
`include "assert_macros.svh"
module polyline_point_store_unit import pps_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int MAX_LINES  = MaxLinesDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic signed [15:0] in_point_x_in,
  input  logic signed [15:0] in_point_y_in,
  input  logic [9:0]  in_point_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_found_index,
  output logic [33:0] out_best_distance,
  output logic [10:0] out_point_count,
  output logic [8:0]  out_line_count
);
  localparam int PA = $clog2(MAX_POINTS);
  localparam int LA = $clog2(MAX_LINES);
  localparam int PC = $clog2(MAX_POINTS + 1);
  localparam int LC = $clog2(MAX_LINES + 1);
  localparam int CW = COORD_BITS;

  state_t state_r, state_nxt;
  logic [2:0] mode_r;
  logic signed [CW-1:0] x_r, y_r;
  logic [PC-1:0] idx_r, np_r, np_nxt, i_r, i_nxt;
  logic [LC-1:0] nl_r, nl_nxt, k_r, k_nxt;
  logic [PC-1:0] begin_r, begin_nxt;
  logic [DistW-1:0] best_r, best_nxt;
  logic [PC-1:0] found_r, found_nxt;
  logic [1:0] st_r, st_nxt;

  // RAM ports
  logic p_we, l_we;
  logic [PA-1:0] p_wa, p_ra;
  logic [LA-1:0] l_wa, l_ra;
  logic [CW-1:0] px_wd, py_wd, px_rd, py_rd;
  logic [PC-1:0] l_wd, l_rd;
  logic [DistW-1:0] dsq;

  pps_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_x (.clk, .we(p_we), .waddr(p_wa),
    .wdata(px_wd), .raddr(p_ra), .rdata(px_rd));
  pps_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_y (.clk, .we(p_we), .waddr(p_wa),
    .wdata(py_wd), .raddr(p_ra), .rdata(py_rd));
  pps_ram #(.WIDTH(PC), .DEPTH(MAX_LINES)) u_len (.clk, .we(l_we), .waddr(l_wa),
    .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  pps_dist #(.CW(CW)) u_dist (.clk, .qx(x_r), .qy(y_r), .px(px_rd), .py(py_rd),
    .dsq(dsq));

  logic accept;
  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  // Next state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    np_nxt = np_r; nl_nxt = nl_r; i_nxt = i_r; k_nxt = k_r;
    begin_nxt = begin_r; best_nxt = best_r; found_nxt = found_r; st_nxt = st_r;
    case (state_r)
      S_IDLE: if (accept) begin
        st_nxt = ST_OK; found_nxt = '0; best_nxt = '0;
        state_nxt = S_DONE;
        case (in_mode)
          MODE_APPEND, MODE_START: begin
            if ((in_mode == MODE_START || nl_r == '0) &&
                (np_r >= PC'(MAX_POINTS) || nl_r >= LC'(MAX_LINES)))
              st_nxt = ST_FULL;
            else if (np_r >= PC'(MAX_POINTS)) st_nxt = ST_FULL;
            else state_nxt = (in_mode == MODE_START || nl_r == '0) ? S_LWRITE
                                                                 : S_LREAD;
          end
          MODE_UPDATE, MODE_DELETE: begin
            if (np_r == '0) st_nxt = ST_EMPTY;
            else if (PC'(in_point_index) >= np_r) st_nxt = ST_RANGE;
            else if (in_mode == MODE_DELETE) begin
              i_nxt = PC'(in_point_index);
              state_nxt = S_SHREAD;
            end
          end
          MODE_SEARCH: begin
            if (np_r == '0) st_nxt = ST_EMPTY;
            else begin
              i_nxt = '0;
              state_nxt = S_SREAD;
            end
          end
          default: ;
        endcase
      end
      S_LWRITE: begin
        np_nxt = np_r + 1'b1; nl_nxt = nl_r + 1'b1; state_nxt = S_DONE;
      end
      S_LREAD: state_nxt = S_LINC;
      S_LINC: begin
        np_nxt = np_r + 1'b1; state_nxt = S_DONE;
      end
      S_SHREAD: begin
        if (i_r + 1'b1 >= np_r) begin
          np_nxt = np_r - 1'b1; k_nxt = '0; begin_nxt = '0;
          state_nxt = S_FINDREAD;
        end else state_nxt = S_SHWRITE;
      end
      S_SHWRITE: begin
        i_nxt = i_r + 1'b1; state_nxt = S_SHREAD;
      end
      S_FINDREAD: state_nxt = S_FINDCHK;
      S_FINDCHK: begin
        if (idx_r < begin_r + l_rd) begin
          if (l_rd == PC'(1)) state_nxt = S_LSHREAD;
          else state_nxt = S_DONE;
        end else begin
          begin_nxt = begin_r + l_rd; k_nxt = k_r + 1'b1;
          state_nxt = (k_r + 1'b1 < nl_r) ? S_FINDREAD : S_DONE;
        end
      end
      S_LSHREAD: begin
        if (k_r + 1'b1 >= nl_r) begin
          nl_nxt = nl_r - 1'b1; state_nxt = S_DONE;
        end else state_nxt = S_LSHWRITE;
      end
      S_LSHWRITE: begin
        k_nxt = k_r + 1'b1; state_nxt = S_LSHREAD;
      end
      S_SREAD: state_nxt = S_SDIFF;
      S_SDIFF: state_nxt = S_SCALC;
      S_SCALC: begin
        if (i_r == '0 || dsq < best_r) begin
          best_nxt = dsq; found_nxt = i_r;
        end
        i_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 < np_r) ? S_SREAD : S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM control. The read address is issued in S_SREAD, the point arrives
  // in S_SDIFF where the distance unit registers its differences, and the
  // squared distance is ready for the compare in S_SCALC.
  always_comb begin
    p_we = 1'b0; l_we = 1'b0;
    p_wa = PA'(np_r); p_ra = PA'(i_r);
    px_wd = x_r; py_wd = y_r;
    l_wa = LA'(nl_r); l_ra = LA'(k_r); l_wd = PC'(1);
    case (state_r)
      S_LWRITE: begin p_we = 1'b1; l_we = 1'b1; end
      S_LREAD: l_ra = LA'(nl_r - 1'b1);
      S_LINC: begin
        p_we = 1'b1; l_we = 1'b1; l_wa = LA'(nl_r - 1'b1); l_wd = l_rd + 1'b1;
      end
      S_SHREAD: p_ra = PA'(i_r + 1'b1);
      S_SHWRITE: begin
        p_we = 1'b1; p_wa = PA'(i_r); px_wd = px_rd; py_wd = py_rd;
      end
      S_FINDCHK: begin
        l_we = (idx_r < begin_r + l_rd); l_wa = LA'(k_r); l_wd = l_rd - 1'b1;
      end
      S_LSHREAD: l_ra = LA'(k_r + 1'b1);
      S_LSHWRITE: begin l_we = 1'b1; l_wa = LA'(k_r); l_wd = l_rd; end
      S_DONE: begin
        p_we = (mode_r == MODE_UPDATE) && (st_r == ST_OK); p_wa = PA'(idx_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; np_r <= '0; nl_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; np_r <= np_nxt; nl_r <= nl_nxt;
      if (state_r == S_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; k_r <= k_nxt; begin_r <= begin_nxt;
    best_r <= best_nxt; found_r <= found_nxt; st_r <= st_nxt;
    if (accept) begin
      mode_r <= in_mode; x_r <= CW'(in_point_x_in); y_r <= CW'(in_point_y_in);
      idx_r <= PC'(in_point_index);
    end
    if (state_r == S_DONE) begin
      out_status <= st_r; out_found_index <= 10'(found_r);
      out_best_distance <= best_r;
      out_point_count <= 11'(np_r); out_line_count <= 9'(nl_r);
    end
  end

  `ASSERT_IMPL(a_cnt, clk, rst_n, 1'b1, np_r <= PC'(MAX_POINTS) && nl_r <= LC'(MAX_LINES))
  `ASSERT_IMPL(a_busy, clk, rst_n, state_r != S_IDLE, !in_ready)
  `ASSERT_NEXT(a_done, clk, rst_n, state_r == S_DONE, out_valid)
endmodule

### design/pps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/pps_dist.sv
// ----------------------------------------------------------------------------
// Squared distance unit
// Squared distance with registered differences and saturation.
// ----------------------------------------------------------------------------
module pps_dist import pps_pkg::*; #(
  parameter int CW = CoordBitsDef
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] qx,
  input  logic signed [CW-1:0] qy,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  output logic [DistW-1:0]     dsq
);
  logic [CW:0] dx, dy;
  logic [CW:0] dx_r, dy_r;
  logic [2*CW+1:0] ext_x, ext_y, sq_x, sq_y;
  logic [2*CW+2:0] sum;
  always_comb begin
    logic signed [CW:0] a, b;
    a = {qx[CW-1], qx} - {px[CW-1], px};
    b = {qy[CW-1], qy} - {py[CW-1], py};
    dx = a[CW] ? -a : a;
    dy = b[CW] ? -b : b;
  end
  always_ff @(posedge clk) begin
    dx_r <= dx;
    dy_r <= dy;
  end
  // The magnitudes are CW+1 bits, so each square is held at full width.
  assign ext_x = (2*CW+2)'(dx_r);
  assign ext_y = (2*CW+2)'(dy_r);
  assign sq_x = ext_x * ext_x;
  assign sq_y = ext_y * ext_y;
  assign sum = {1'b0, sq_x} + {1'b0, sq_y};
  always_comb begin
    if (sum > (2*CW+3)'({DistW{1'b1}})) dsq = {DistW{1'b1}};
    else dsq = DistW'(sum);
  end
endmodule
